@@ rtl/fde_pkg.sv @@
// shared types, constants and codes for the flag delimited bit frame extractor
`timescale 1ns / 1ps
package fde_pkg;

   // defaults for the top level parameters
   localparam int MAX_FLAG_BITS_DEF = 64;
   localparam int POSITION_BITS_DEF = 48;

   // fixed field widths
   localparam int PATTERN_W = 64;
   localparam int LENGTH_W  = 7;
   localparam int OUT_POS_W = 48;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 64;

   localparam logic [LENGTH_W-1:0] LENGTH_RESET = 7'd8;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_START_PATTERN = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_START_LENGTH  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_END_PATTERN   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_END_LENGTH    = 3'd3;

   // request kinds
   localparam logic REQ_DATA_BIT = 1'b0;
   localparam logic REQ_END      = 1'b1;

   // status codes
   localparam logic STATUS_OK        = 1'b0;
   localparam logic STATUS_NOT_FOUND = 1'b1;

   typedef struct packed {
      logic req_type;
      logic bit_value;
   } req_data_type;

   typedef struct packed {
      logic [7:0]           payload_byte;
      logic                 has_payload;
      logic                 is_last;
      logic                 status;
      logic [OUT_POS_W-1:0] start_position;
      logic [OUT_POS_W-1:0] end_position;
   } rsp_data_type;

   typedef struct packed {
      logic [PATTERN_W-1:0] start_pattern;
      logic [LENGTH_W-1:0]  start_length;
      logic [PATTERN_W-1:0] end_pattern;
      logic [LENGTH_W-1:0]  end_length;
   } cfg_type;

endpackage

@@ rtl/fde_cfg.sv @@
// configuration register file of the frame extractor
`timescale 1ns / 1ps
module fde_cfg (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_enable,
   input  logic [fde_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [fde_pkg::CSR_DATA_W-1:0]   csr_write_data,
   output fde_pkg::cfg_type                 cfg
);

   fde_pkg::cfg_type cfg_ff;
   fde_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            fde_pkg::CSR_START_PATTERN: cfg_in.start_pattern = csr_write_data;
            fde_pkg::CSR_START_LENGTH:
               cfg_in.start_length = csr_write_data[fde_pkg::LENGTH_W-1:0];
            fde_pkg::CSR_END_PATTERN: cfg_in.end_pattern = csr_write_data;
            fde_pkg::CSR_END_LENGTH:
               cfg_in.end_length = csr_write_data[fde_pkg::LENGTH_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_pattern <= '0;
         cfg_ff.start_length  <= fde_pkg::LENGTH_RESET;
         cfg_ff.end_pattern   <= '0;
         cfg_ff.end_length    <= fde_pkg::LENGTH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ rtl/fde_core.sv @@
// flag search, delay window, byte packing and result register
`timescale 1ns / 1ps
module fde_core #(
   parameter int MAX_FLAG_BITS = fde_pkg::MAX_FLAG_BITS_DEF,
   parameter int POSITION_BITS = fde_pkg::POSITION_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  fde_pkg::req_data_type item,
   input  fde_pkg::cfg_type      cfg,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output fde_pkg::rsp_data_type rsp_data
);

   localparam int LEN_W = $clog2(MAX_FLAG_BITS + 1);
   localparam int IDX_W = (MAX_FLAG_BITS > 1) ? $clog2(MAX_FLAG_BITS) : 1;

   typedef enum logic [1:0] {
      PH_SEEK,
      PH_FRAME,
      PH_DONE
   } phase_type;

   phase_type                  phase_ff, phase_in;
   logic [MAX_FLAG_BITS-1:0]   hist_ff, hist_in;
   logic [LEN_W-1:0]           cnt_ff, cnt_in;
   logic [POSITION_BITS-1:0]   pos_ff, pos_in;
   logic [POSITION_BITS-1:0]   saved_ff, saved_in;
   logic [7:0]                 acc_ff, acc_in;
   logic [2:0]                 nb_ff, nb_in;
   logic                       rsp_valid_ff;
   fde_pkg::rsp_data_type      rsp_data_ff;

   logic                       res_valid;
   fde_pkg::rsp_data_type      res;
   logic [LEN_W-1:0]           s_len, e_len;
   logic [MAX_FLAG_BITS-1:0]   s_mask, e_mask;
   logic [MAX_FLAG_BITS-1:0]   hist_sh;
   logic [LEN_W-1:0]           cnt_inc;
   logic [POSITION_BITS-1:0]   pos_inc;
   logic                       have_delayed;
   logic                       delayed;
   logic [7:0]                 acc_pk;
   logic                       start_hit, end_hit;

   function automatic logic [LEN_W-1:0] eff_len(input logic [fde_pkg::LENGTH_W-1:0] len);
      logic [LEN_W-1:0] r;
      if (len == '0) begin
         r = LEN_W'(1);
      end else if (int'(len) > MAX_FLAG_BITS) begin
         r = LEN_W'(MAX_FLAG_BITS);
      end else begin
         r = LEN_W'(len);
      end
      return r;
   endfunction

   function automatic logic [MAX_FLAG_BITS-1:0] low_mask(input logic [LEN_W-1:0] len);
      logic [MAX_FLAG_BITS-1:0] m;
      for (int i = 0; i < MAX_FLAG_BITS; i++) begin
         m[i] = (i < int'(len));
      end
      return m;
   endfunction

   function automatic logic [fde_pkg::OUT_POS_W-1:0] out_pos(
      input logic [POSITION_BITS-1:0] p);
      logic [63:0] w;
      w = 64'(p);
      return w[fde_pkg::OUT_POS_W-1:0];
   endfunction

   assign s_len   = eff_len(cfg.start_length);
   assign e_len   = eff_len(cfg.end_length);
   assign s_mask  = low_mask(s_len);
   assign e_mask  = low_mask(e_len);
   assign hist_sh = MAX_FLAG_BITS'({hist_ff, item.bit_value});
   assign cnt_inc = (cnt_ff < LEN_W'(MAX_FLAG_BITS)) ? cnt_ff + 1'b1 : cnt_ff;
   assign pos_inc = (pos_ff != '1) ? pos_ff + 1'b1 : pos_ff;

   // delay window tap: oldest bit still inside the end flag length
   assign have_delayed = (cnt_ff >= e_len);
   assign delayed      = hist_ff[IDX_W'(e_len - LEN_W'(1))];
   assign acc_pk       = acc_ff | (8'(delayed) << (3'd7 - nb_ff));

   assign start_hit = (cnt_inc >= s_len) &&
                      (((hist_sh ^ cfg.start_pattern[MAX_FLAG_BITS-1:0]) & s_mask) == '0);
   assign end_hit   = (cnt_inc >= e_len) &&
                      (((hist_sh ^ cfg.end_pattern[MAX_FLAG_BITS-1:0]) & e_mask) == '0);

   always_comb begin
      phase_in  = phase_ff;
      hist_in   = hist_ff;
      cnt_in    = cnt_ff;
      pos_in    = pos_ff;
      saved_in  = saved_ff;
      acc_in    = acc_ff;
      nb_in     = nb_ff;
      res_valid = 1'b0;
      res       = '0;
      res.status = fde_pkg::STATUS_OK;

      if (item.req_type == fde_pkg::REQ_END) begin
         if (phase_ff != PH_DONE) begin
            res_valid          = 1'b1;
            res.is_last        = 1'b1;
            res.status         = fde_pkg::STATUS_NOT_FOUND;
            res.start_position = (phase_ff == PH_FRAME) ? out_pos(saved_ff) : '0;
         end
         phase_in = PH_SEEK;
         hist_in  = '0;
         cnt_in   = '0;
         pos_in   = '0;
         saved_in = '0;
         acc_in   = '0;
         nb_in    = '0;
      end else begin
         unique case (phase_ff)
            PH_SEEK: begin
               pos_in  = pos_inc;
               hist_in = hist_sh;
               cnt_in  = cnt_inc;
               if (start_hit) begin
                  saved_in = pos_inc - POSITION_BITS'(s_len);
                  phase_in = PH_FRAME;
                  hist_in  = '0;
                  cnt_in   = '0;
               end
            end
            PH_FRAME: begin
               pos_in  = pos_inc;
               hist_in = hist_sh;
               cnt_in  = cnt_inc;
               if (end_hit) begin
                  res_valid          = 1'b1;
                  res.is_last        = 1'b1;
                  res.has_payload    = have_delayed || (nb_ff != '0);
                  res.payload_byte   = have_delayed ? acc_pk : acc_ff;
                  res.start_position = out_pos(saved_ff);
                  res.end_position   = out_pos(pos_inc - POSITION_BITS'(e_len));
                  acc_in   = '0;
                  nb_in    = '0;
                  phase_in = PH_DONE;
               end else if (have_delayed) begin
                  if (nb_ff == 3'd7) begin
                     res_valid          = 1'b1;
                     res.has_payload    = 1'b1;
                     res.payload_byte   = acc_pk;
                     res.start_position = out_pos(saved_ff);
                     acc_in = '0;
                     nb_in  = '0;
                  end else begin
                     acc_in = acc_pk;
                     nb_in  = nb_ff + 3'd1;
                  end
               end
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_SEEK;
         hist_ff      <= '0;
         cnt_ff       <= '0;
         pos_ff       <= '0;
         saved_ff     <= '0;
         acc_ff       <= '0;
         nb_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_data_ff  <= '0;
      end else if (advance) begin
         phase_ff     <= phase_in;
         hist_ff      <= hist_in;
         cnt_ff       <= cnt_in;
         pos_ff       <= pos_in;
         saved_ff     <= saved_in;
         acc_ff       <= acc_in;
         nb_ff        <= nb_in;
         rsp_valid_ff <= res_valid;
         if (res_valid) begin
            rsp_data_ff <= res;
         end
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a mid-frame byte always carries payload and ok status
   a_mid_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.is_last |->
         rsp_data_ff.has_payload && rsp_data_ff.status == fde_pkg::STATUS_OK)
      else $error("mid-frame result without payload");

   // not-found status never carries payload or an end position
   a_not_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.status == fde_pkg::STATUS_NOT_FOUND |->
         !rsp_data_ff.has_payload && rsp_data_ff.end_position == '0 &&
         rsp_data_ff.is_last)
      else $error("bad not-found result");

   // end of stream returns the stream state to its start
   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      advance && item.req_type == fde_pkg::REQ_END |=>
         phase_ff == PH_SEEK && pos_ff == '0 && nb_ff == '0)
      else $error("end of stream did not clear state");

   // data bits after a finished frame give nothing
   a_done_quiet: assert property (@(posedge clock) disable iff (reset)
      advance && phase_ff == PH_DONE && item.req_type == fde_pkg::REQ_DATA_BIT |=>
         !rsp_valid_ff && phase_ff == PH_DONE)
      else $error("result after finished frame");

endmodule

@@ rtl/flag_delimited_bit_frame_extractor_top.sv @@
// top level of the flag delimited bit frame extractor
`timescale 1ns / 1ps
// usage
//   req channel: one request per stream bit (req_type data bit) or one end of
//     stream marker (req_type end); req_valid / req_ready handshake
//   rsp channel: zero or one result per request, full payload bytes mid-frame,
//     a final is_last result at the end flag, or a not-found status at end of
//     stream; rsp_valid / rsp_ready handshake
//   csr port: write-only, csr_index 0..3 = start pattern, start length,
//     end pattern, end length; write only while the block is idle
//   path: a request is held in the input register, its result in the result register
//   throughput: one request per cycle unless a held result stalls; the input
//     and result registers overlap, so a new request is taken while a result waits
//   flag compare, delay tap and byte packing are all combinational between
//     the input register and the result register
//   stall: when rsp_ready is low and a result is held, at most one more
//     request sits in the input register, then req_ready drops
//   reset: synchronous, clears both channels and the stream state; lengths
//     return to 8 and patterns to zero
module flag_delimited_bit_frame_extractor_top #(
   parameter int MAX_FLAG_BITS = fde_pkg::MAX_FLAG_BITS_DEF,
   parameter int POSITION_BITS = fde_pkg::POSITION_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  fde_pkg::req_data_type           req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output fde_pkg::rsp_data_type           rsp_data,
   input  logic                            csr_write_enable,
   input  logic [fde_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [fde_pkg::CSR_DATA_W-1:0]  csr_write_data
);

   fde_pkg::cfg_type      cfg;
   logic                  in_valid_ff;
   fde_pkg::req_data_type in_data_ff;
   logic                  advance;

   // the held request moves on when the result register is free or draining
   assign advance   = in_valid_ff && (!rsp_valid || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   // input payload register, no reset needed
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
   end

   // register file
   fde_cfg u_cfg (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   // matcher, packer and result register
   fde_core #(
      .MAX_FLAG_BITS (MAX_FLAG_BITS),
      .POSITION_BITS (POSITION_BITS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .item      (in_data_ff),
      .cfg       (cfg),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
